[rtl/pbn_pkg.sv]
// Shared types, codes and the control store of the palette remap block.
`default_nettype none
package pbn_pkg;

  // Item operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic REG_OP_COLOR     = 1'b0;
  localparam logic REG_BLEND_WEIGHT = 1'b1;

  localparam logic [7:0]  LAST_INDEX  = 8'hff;
  localparam logic [14:0] START_LIMIT = 15'h7fff;

  typedef logic [3:0] step_t;

  localparam step_t ST_IDLE   = 4'd0;
  localparam step_t ST_ZCHK   = 4'd1;
  localparam step_t ST_RD_ENT = 4'd2;
  localparam step_t ST_LD_ENT = 4'd3;
  localparam step_t ST_MUL    = 4'd4;
  localparam step_t ST_BLEND  = 4'd5;
  localparam step_t ST_SEARCH = 4'd6;
  localparam step_t ST_DRAIN1 = 4'd7;
  localparam step_t ST_DRAIN2 = 4'd8;
  localparam step_t ST_EMIT   = 4'd9;

  typedef enum logic [1:0] {
    A_OC,
    A_ENT,
    A_CAND
  } addr_sel_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_START,
    C_ZERO,
    C_MORE,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    logic      in_rdy;
    addr_sel_t asel;
    logic      ld_ref;
    logic      ld_ent;
    logic      mul;
    logic      blend;
    logic      issue;
    logic      emit;
    cond_t     cond;
    step_t     jt;
    step_t     jf;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic is_zero;
    logic more;
    logic out_free;
  } stat_t;

  // Control store: one word per step
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t cw;
    cw      = '0;
    cw.asel = A_OC;
    cw.cond = C_ALWAYS;
    case (step)
      ST_IDLE: begin
        cw.in_rdy = 1'b1;
        cw.cond   = C_START;
        cw.jt     = ST_ZCHK;
        cw.jf     = ST_IDLE;
      end
      ST_ZCHK: begin
        cw.cond = C_ZERO;
        cw.jt   = ST_EMIT;
        cw.jf   = ST_RD_ENT;
      end
      ST_RD_ENT: begin
        cw.asel   = A_ENT;
        cw.ld_ref = 1'b1;
        cw.jt     = ST_LD_ENT;
        cw.jf     = ST_LD_ENT;
      end
      ST_LD_ENT: begin
        cw.ld_ent = 1'b1;
        cw.jt     = ST_MUL;
        cw.jf     = ST_MUL;
      end
      ST_MUL: begin
        cw.mul = 1'b1;
        cw.jt  = ST_BLEND;
        cw.jf  = ST_BLEND;
      end
      ST_BLEND: begin
        cw.blend = 1'b1;
        cw.jt    = ST_SEARCH;
        cw.jf    = ST_SEARCH;
      end
      ST_SEARCH: begin
        cw.asel  = A_CAND;
        cw.issue = 1'b1;
        cw.cond  = C_MORE;
        cw.jt    = ST_SEARCH;
        cw.jf    = ST_DRAIN1;
      end
      ST_DRAIN1: begin
        cw.jt = ST_DRAIN2;
        cw.jf = ST_DRAIN2;
      end
      ST_DRAIN2: begin
        cw.jt = ST_EMIT;
        cw.jf = ST_EMIT;
      end
      ST_EMIT: begin
        cw.emit = 1'b1;
        cw.cond = C_OUT_FREE;
        cw.jt   = ST_IDLE;
        cw.jf   = ST_EMIT;
      end
      default: begin
        cw.jt = ST_IDLE;
        cw.jf = ST_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage
`default_nettype wire

[rtl/pbn_if.sv]
// Valid/ready channel interfaces for input words and result words.
`default_nettype none
interface pbn_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] entry_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output operation, output entry_index,
                  output red, output green, output blue, input ready);
  modport sink   (input valid, input operation, input entry_index,
                  input red, input green, input blue, output ready);
endinterface

interface pbn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] queried_index;
  logic [7:0] remap_value;

  modport source (output valid, output queried_index, output remap_value,
                  input ready);
  modport sink   (input valid, input queried_index, input remap_value,
                  output ready);
endinterface
`default_nettype wire

[rtl/pbn_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module pbn_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/pbn_seq.sv]
// Microcode sequencer: step counter, control store and branch logic.
`default_nettype none
module pbn_seq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire pbn_pkg::stat_t stat,
  output pbn_pkg::ctrl_t      ctrl
);

  pbn_pkg::step_t step_r;
  pbn_pkg::step_t step_nxt;
  logic           take;

  assign ctrl = pbn_pkg::ucode(step_r);

  always_comb begin
    case (ctrl.cond)
      pbn_pkg::C_ALWAYS:   take = 1'b1;
      pbn_pkg::C_START:    take = stat.start;
      pbn_pkg::C_ZERO:     take = stat.is_zero;
      pbn_pkg::C_MORE:     take = stat.more;
      pbn_pkg::C_OUT_FREE: take = stat.out_free;
      default:             take = 1'b1;
    endcase
    step_nxt = take ? ctrl.jt : ctrl.jf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= pbn_pkg::ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/pbn_dp.sv]
// Datapath: blend unit, pipelined distance search and result register.
`default_nettype none
module pbn_dp #(
  parameter int PALETTE_DEPTH  = 256,
  parameter int SEARCH_ENTRIES = 127
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire pbn_pkg::ctrl_t                   ctrl,
  output pbn_pkg::stat_t                        stat,
  input  wire logic [7:0]                       op_color,
  input  wire logic [7:0]                       blend_weight,
  pbn_in_if.sink                                in_ch,
  pbn_out_if.source                             out_ch,
  output logic                                  ram_we,
  output logic      [$clog2(PALETTE_DEPTH)-1:0] ram_waddr,
  output logic      [23:0]                      ram_wdata,
  output logic      [$clog2(PALETTE_DEPTH)-1:0] ram_raddr,
  input  wire logic [23:0]                      ram_rdata
);

  localparam int         AW        = $clog2(PALETTE_DEPTH);
  localparam logic [7:0] LAST_CAND = 8'(SEARCH_ENTRIES);

  // index -> palette address, modulo the depth
  logic [AW-1:0] wrap_tab [256];
  for (genvar g = 0; g < 256; g++) begin : g_wrap
    assign wrap_tab[g] = AW'(g % PALETTE_DEPTH);
  end

  logic               in_acc;
  logic [7:0]         qidx_r, qidx_nxt;
  logic [23:0]        ref_r, ref_nxt;
  logic [23:0]        ent_r, ent_nxt;
  logic signed [16:0] prod_r [3];
  logic signed [16:0] prod_nxt [3];
  logic [7:0]         blend_r [3];
  logic [7:0]         blend_nxt [3];
  logic [7:0]         x_r, x_nxt;
  logic               v0_r, v0_nxt;
  logic [7:0]         x0_r;
  logic               v1_r;
  logic [7:0]         x1_r;
  logic [16:0]        sq_r [3];
  logic [16:0]        sq_nxt [3];
  logic [17:0]        cand_dist;
  logic [14:0]        limit_r, limit_nxt;
  logic [7:0]         best_r, best_nxt;
  logic               hit_r, hit_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_qidx_r, out_qidx_nxt;
  logic [7:0]         out_val_r, out_val_nxt;

  assign in_ch.ready = ctrl.in_rdy;
  assign in_acc      = in_ch.valid && ctrl.in_rdy;

  // Palette writes are taken straight from the input word
  assign ram_we    = in_acc && (in_ch.operation == pbn_pkg::OP_WRITE);
  assign ram_waddr = wrap_tab[in_ch.entry_index];
  assign ram_wdata = {in_ch.red, in_ch.green, in_ch.blue};

  always_comb begin
    case (ctrl.asel)
      pbn_pkg::A_OC:   ram_raddr = wrap_tab[op_color];
      pbn_pkg::A_ENT:  ram_raddr = wrap_tab[qidx_r];
      pbn_pkg::A_CAND: ram_raddr = wrap_tab[x_r];
      default:         ram_raddr = wrap_tab[op_color];
    endcase
  end

  assign stat.start    = in_acc && (in_ch.operation == pbn_pkg::OP_QUERY) &&
                         (in_ch.entry_index != pbn_pkg::LAST_INDEX);
  assign stat.is_zero  = (qidx_r == 8'd0);
  assign stat.more     = (x_r != LAST_CAND);
  assign stat.out_free = !out_valid_r || out_ch.ready;

  assign cand_dist = 18'(sq_r[0]) + 18'(sq_r[1]) + 18'(sq_r[2]);

  always_comb begin
    logic signed [8:0]  dif;
    logic signed [17:0] sqf;
    qidx_nxt  = stat.start ? in_ch.entry_index : qidx_r;
    ref_nxt   = ctrl.ld_ref ? ram_rdata : ref_r;
    ent_nxt   = ctrl.ld_ent ? ram_rdata : ent_r;
    for (int c = 0; c < 3; c++) begin
      // (a - ref) * (weight >> 1); the doubling and >> 8 fold into >>> 7
      dif = $signed({1'b0, ent_r[c*8 +: 8]}) - $signed({1'b0, ref_r[c*8 +: 8]});
      prod_nxt[c]  = ctrl.mul ? 17'(dif * $signed({1'b0, blend_weight[7:1]}))
                              : prod_r[c];
      blend_nxt[c] = ctrl.blend ? (ent_r[c*8 +: 8] - prod_r[c][14:7]) : blend_r[c];
      dif = $signed({1'b0, ram_rdata[c*8 +: 8]}) - $signed({1'b0, blend_r[c]});
      sqf = dif * dif;
      sq_nxt[c] = sqf[16:0];
    end

    x_nxt     = x_r;
    v0_nxt    = 1'b0;
    limit_nxt = limit_r;
    best_nxt  = best_r;
    hit_nxt   = hit_r;
    if (ctrl.blend) begin
      x_nxt     = 8'd1;
      limit_nxt = pbn_pkg::START_LIMIT;
      best_nxt  = op_color;
      hit_nxt   = 1'b0;
    end else if (v1_r && !hit_r) begin
      if (cand_dist == 18'd0) begin
        best_nxt = x1_r;
        hit_nxt  = 1'b1;
      end else if (cand_dist <= {3'b000, limit_r}) begin
        best_nxt  = x1_r;
        limit_nxt = cand_dist[14:0];
      end
    end
    if (ctrl.issue) begin
      v0_nxt = (x_r != qidx_r);
      x_nxt  = x_r + 8'd1;
    end

    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_qidx_nxt  = out_qidx_r;
    out_val_nxt   = out_val_r;
    if (ctrl.emit && stat.out_free) begin
      out_valid_nxt = 1'b1;
      out_qidx_nxt  = qidx_r;
      out_val_nxt   = stat.is_zero ? 8'd0 : best_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v0_r        <= v0_nxt;
      v1_r        <= v0_r;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    qidx_r     <= qidx_nxt;
    ref_r      <= ref_nxt;
    ent_r      <= ent_nxt;
    prod_r     <= prod_nxt;
    blend_r    <= blend_nxt;
    sq_r       <= sq_nxt;
    x_r        <= x_nxt;
    x0_r       <= x_r;
    x1_r       <= x0_r;
    limit_r    <= limit_nxt;
    best_r     <= best_nxt;
    out_qidx_r <= out_qidx_nxt;
    out_val_r  <= out_val_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.queried_index = out_qidx_r;
  assign out_ch.remap_value   = out_val_r;

endmodule
`default_nettype wire

[rtl/palette_blend_nearest_remap.sv]
// Top level of the palette blend nearest-color remap block.
`default_nettype none
// Holds a PALETTE_DEPTH-entry RGB palette in a RAM. A write word (operation 0)
// stores one entry when accepted and yields no result. A query word
// (operation 1) for index i yields one result word {queried_index, remap_value}:
// index 0 gives 0, index 255 gives nothing, any other index blends entry i
// toward the op_color entry by blend_weight and returns the nearest entry
// among 1..SEARCH_ENTRIES (i excluded), the later one winning a tie, an exact
// match fixing the result, or op_color if none is within 0x7fff.
// A query holds the block busy from acceptance until its result is registered;
// the search reads one palette entry per cycle through the RAM's single read
// port, feeding a square-then-compare pipeline. The result register lets the
// next word in while a result waits to be taken; a query that finishes while
// the previous result is still held waits for it. Palette contents are
// undefined until written. Configuration (op_color, blend_weight) is written
// through cfg_we/cfg_index/cfg_wdata; the user must do so only while idle,
// as the block itself does not enforce it.

module palette_blend_nearest_remap #(
  parameter int PALETTE_DEPTH  = 256,
  parameter int SEARCH_ENTRIES = 127
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata,
  pbn_in_if.sink          in_ch,
  pbn_out_if.source       out_ch
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  // Configuration registers
  logic [7:0] op_color_r, op_color_nxt;
  logic [7:0] blend_weight_r, blend_weight_nxt;

  always_comb begin
    op_color_nxt     = op_color_r;
    blend_weight_nxt = blend_weight_r;
    if (cfg_we) begin
      case (cfg_index)
        pbn_pkg::REG_OP_COLOR:     op_color_nxt     = cfg_wdata;
        pbn_pkg::REG_BLEND_WEIGHT: blend_weight_nxt = cfg_wdata;
        default:                   op_color_nxt     = op_color_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_color_r     <= 8'd0;
      blend_weight_r <= 8'd0;
    end else begin
      op_color_r     <= op_color_nxt;
      blend_weight_r <= blend_weight_nxt;
    end
  end

  pbn_pkg::ctrl_t ctrl;
  pbn_pkg::stat_t stat;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [23:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [23:0]   ram_rdata;

  // Sequencer walks the control store; the datapath reports branch conditions
  pbn_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .ctrl (ctrl)
  );

  pbn_dp #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .SEARCH_ENTRIES(SEARCH_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .stat        (stat),
    .op_color    (op_color_r),
    .blend_weight(blend_weight_r),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  // Palette store: {red, green, blue}
  pbn_ram #(
    .WIDTH(24),
    .DEPTH(PALETTE_DEPTH)
  ) u_pal (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule
`default_nettype wire

[rtl/pbn_chk.sv]
// Port-level assertions for the palette remap block and their bind.
`default_nettype none
module pbn_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       operation,
  input wire logic [7:0] entry_index,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] queried_index,
  input wire logic [7:0] remap_value
);

  a_no_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> queried_index != 8'hff)
    else $error("result word for index 255");

  a_zero_maps_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && queried_index == 8'd0) |-> remap_value == 8'd0)
    else $error("index 0 did not map to 0");

  a_busy_after_query: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && operation && entry_index != 8'hff) |=> !in_ready)
    else $error("ready right after a query word");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result word dropped while stalled");

endmodule

bind palette_blend_nearest_remap pbn_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .operation    (in_ch.operation),
  .entry_index  (in_ch.entry_index),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .queried_index(out_ch.queried_index),
  .remap_value  (out_ch.remap_value)
);
`default_nettype wire
